FILE: rtl/core/lslf_pkg.sv
package lslf_pkg;

  localparam int MAX_POINTS  = 65536;
  localparam int SAMPLE_BITS = 16;

  // Accumulator widths.
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUMX_W = CNT_W + SAMPLE_BITS;
  localparam int SQ_W   = CNT_W + 2 * SAMPLE_BITS - 2;
  localparam int XY_W   = CNT_W + 2 * SAMPLE_BITS - 1;

  // Working width of the shared arithmetic unit; even for the square root.
  localparam int W      = 2 * ((5 * CNT_W + 4 * SAMPLE_BITS + 25) / 2);
  localparam int ITER_W = $clog2(W + 1);

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic [16:0]        r_squared;
    logic [16:0]        correlation;
    logic signed [31:0] adjusted_r_squared;
    logic [31:0]        standard_error;
    logic [16:0]        point_count;
    logic [1:0]         fit_status;
  } out_word_t;

  typedef enum logic [1:0] {
    FS_OK       = 2'd0,
    FS_X_FLAT   = 2'd1,
    FS_Y_FLAT   = 2'd2,
    FS_FEW_PTS  = 2'd3
  } fit_status_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_RDIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_PREP,
    AL_RUN,
    AL_FIX,
    AL_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_LAUNCH,
    CT_WAIT,
    CT_OUT
  } ctl_state_t;

  typedef enum logic [4:0] {
    SP_NSXX, SP_SXSX, SP_NSYY, SP_SYSY, SP_NSXY, SP_SXSY, SP_SLOPE,
    SP_SYSXX, SP_SXSXY, SP_ICPT, SP_DD, SP_N2, SP_R2, SP_CDIV, SP_CSQRT,
    SP_A1, SP_A2, SP_A3, SP_E1, SP_E2, SP_E3, SP_E4
  } step_t;

  localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};

  function automatic logic [W-1:0] clamp_u(input logic [W-1:0] v, input logic [W-1:0] lim);
    clamp_u = (v > lim) ? lim : v;
  endfunction

  // Saturate a two's complement value to 48 signed bits.
  function automatic logic [47:0] sat_s48(input logic [W-1:0] v);
    logic           neg;
    logic [W-1:0]   m;
    logic [W-1:0]   lim;
    neg = v[W-1];
    m   = neg ? (~v + ONE_W) : v;
    lim = neg ? (ONE_W << 47) : ((ONE_W << 47) - ONE_W);
    if (m > lim) m = lim;
    m = neg ? (~m + ONE_W) : m;
    sat_s48 = m[47:0];
  endfunction

endpackage

FILE: rtl/core/lslf_alu.sv
module lslf_alu import lslf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req_i,
  input  logic [W-1:0] opa_i,
  input  logic [W-1:0] opb_i,
  output alu_rsp_t     rsp_o,
  output logic [W-1:0] res_o
);

  alu_state_t        state_r, state_nxt;
  alu_op_t           op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic [W-1:0]      x_r, x_nxt;
  logic [W-1:0]      y_r, y_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;

  logic [W-1:0]      rem_sh;
  logic [W-1:0]      root_try;
  logic              div_ge;
  logic              sqrt_ge;

  assign rem_sh   = {acc_r[W-2:0], y_r[W-1]};
  assign div_ge   = (rem_sh >= x_r);
  assign root_try = acc_r + x_r;
  assign sqrt_ge  = (y_r >= root_try);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AL_IDLE: begin
        if (req_i.start) state_nxt = (req_i.op == OP_RDIV) ? AL_PREP : AL_RUN;
      end
      AL_PREP: state_nxt = AL_RUN;
      AL_RUN: begin
        if (cnt_r == ITER_W'(1)) state_nxt = (op_r == OP_RDIV) ? AL_FIX : AL_DONE;
      end
      AL_FIX:  state_nxt = AL_DONE;
      AL_DONE: state_nxt = AL_IDLE;
      default: state_nxt = AL_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    op_nxt  = op_r;
    neg_nxt = neg_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      AL_IDLE: begin
        if (req_i.start) begin
          op_nxt  = req_i.op;
          acc_nxt = '0;
          cnt_nxt = ITER_W'(W);
          unique case (req_i.op)
            OP_MUL: begin
              x_nxt = opa_i;
              y_nxt = opb_i;
            end
            OP_DIV: begin
              x_nxt = opb_i;
              y_nxt = opa_i;
            end
            OP_RDIV: begin
              neg_nxt = opa_i[W-1];
              x_nxt   = opb_i;
              y_nxt   = opa_i[W-1] ? (~opa_i + ONE_W) : opa_i;
            end
            OP_SQRT: begin
              x_nxt   = ONE_W << (W - 2);
              y_nxt   = opa_i;
              cnt_nxt = ITER_W'(W / 2);
            end
            default: x_nxt = opa_i;
          endcase
        end
      end
      AL_PREP: begin
        // Rounded quotient: (2|a| + b) / (2b).
        y_nxt = (y_r << 1) + x_r;
        x_nxt = x_r << 1;
      end
      AL_RUN: begin
        cnt_nxt = cnt_r - ITER_W'(1);
        unique case (op_r)
          OP_MUL: begin
            acc_nxt = y_r[0] ? (acc_r + x_r) : acc_r;
            x_nxt   = x_r << 1;
            y_nxt   = y_r >> 1;
          end
          OP_DIV, OP_RDIV: begin
            acc_nxt = div_ge ? (rem_sh - x_r) : rem_sh;
            y_nxt   = {y_r[W-2:0], div_ge};
          end
          OP_SQRT: begin
            y_nxt   = sqrt_ge ? (y_r - root_try) : y_r;
            acc_nxt = sqrt_ge ? ((acc_r >> 1) + x_r) : (acc_r >> 1);
            x_nxt   = x_r >> 2;
          end
          default: acc_nxt = acc_r;
        endcase
      end
      AL_FIX: begin
        if (neg_r) y_nxt = ~y_r + ONE_W;
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  // Outputs.
  always_comb begin
    rsp_o.busy = (state_r != AL_IDLE);
    rsp_o.done = (state_r == AL_DONE);
    res_o      = (op_r == OP_DIV || op_r == OP_RDIV) ? y_r : acc_r;
  end

endmodule

FILE: rtl/core/least_squares_line_fit.sv
// Least-squares straight-line fit over sets of signed Q8.8 samples.
//
// The input channel (in_valid, in_ready, in_data) carries one sample word
// per handshake. While the block is idle it takes one word per cycle and
// folds it into exact running sums of n, x, y, x*x, y*y and x*y. Once a set
// is full, further samples are dropped, but a last_point mark still counts.
// The word marked last_point starts the fit; in_ready is low until its
// result is loaded into the output register. The fit runs on one shared
// iterative unit (shift-add multiply, restoring divide, digit-by-digit
// square root) under a step sequencer; degenerate sets take fewer steps.
// The result word goes to an output register (out_valid, out_ready,
// out_data). If the receiver stalls, that word is held and the block keeps
// taking samples of the next set; the result of a second fit waits until
// the first is taken. Synchronous active-low reset clears the sums, the
// sequencer and the output valid flag.
module least_squares_line_fit import lslf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Control state.
  ctl_state_t ctl_r, ctl_nxt;
  step_t      step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r;

  // Running sums.
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUMX_W-1:0] sx_r, sy_r;
  logic [SQ_W-1:0]          sxx_r, syy_r;
  logic signed [XY_W-1:0]   sxy_r;

  // Fit temporaries.
  logic [W-1:0] t1_r, t2_r, dxx_r, dyy_r, nxy_r, dd_r, n2_r, resid_r;

  // Result fields.
  logic [47:0]  slope_r, icpt_r;
  logic [16:0]  r2_r, corr_r;
  logic [31:0]  adj_r, serr_r;
  fit_status_t  status_r;

  // Shared unit.
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] opa, opb, alu_res;

  logic in_fire, out_load, wb_en, fit_exit;
  logic signed [SAMPLE_BITS-1:0]   xs, ys;
  logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;
  logic [W-1:0] n_w, nm1_w, nm2_w, sx_w, sy_w, sxx_w, syy_w, sxy_w;
  logic [W-1:0] e_w;
  logic [31:0]  adj_val;

  localparam logic [W-1:0] LIM_R2  = ONE_W << 16;
  localparam logic [W-1:0] LIM_E   = ONE_W << 40;
  localparam logic [W-1:0] LIM_SE  = (ONE_W << 32) - ONE_W;
  localparam logic [W-1:0] ADJ_MIN = (ONE_W << 31) + (ONE_W << 16);

  assign in_fire  = in_valid && in_ready;
  assign out_load = (ctl_r == CT_OUT) && (!out_valid_r || out_ready);
  assign wb_en    = (ctl_r == CT_WAIT) && alu_rsp.done;

  assign xs  = in_data.x_value[SAMPLE_BITS-1:0];
  assign ys  = in_data.y_value[SAMPLE_BITS-1:0];
  assign pxx = xs * xs;
  assign pyy = ys * ys;
  assign pxy = xs * ys;

  assign n_w   = W'(cnt_r);
  assign nm1_w = n_w - ONE_W;
  assign nm2_w = n_w - (ONE_W << 1);
  assign sx_w  = W'(sx_r);
  assign sy_w  = W'(sy_r);
  assign sxx_w = W'(sxx_r);
  assign syy_w = W'(syy_r);
  assign sxy_w = W'(sxy_r);

  // The adjusted R squared is 1 - e, where e is clamped before the subtract.
  assign e_w     = clamp_u(alu_res, LIM_E);
  assign adj_val = (e_w > ADJ_MIN) ? 32'h8000_0000 : 32'((ONE_W << 16) - e_w);

  // A fit ends early for a flat x spread, for too few points or a flat y.
  always_comb begin
    case (step_r)
      SP_SXSY: fit_exit = dxx_r[W-1] || (dxx_r == '0);
      SP_ICPT: fit_exit = (cnt_r <= CNT_W'(2)) || (dyy_r == '0);
      SP_E4:   fit_exit = 1'b1;
      default: fit_exit = 1'b0;
    endcase
  end

  // Operand selection for each step of the fit.
  always_comb begin
    alu_req.start = (ctl_r == CT_LAUNCH);
    alu_req.op    = OP_MUL;
    opa           = n_w;
    opb           = sxx_w;
    unique case (step_r)
      SP_NSXX:  begin opa = n_w;  opb = sxx_w; end
      SP_SXSX:  begin opa = sx_w; opb = sx_w;  end
      SP_NSYY:  begin opa = n_w;  opb = syy_w; end
      SP_SYSY:  begin opa = sy_w; opb = sy_w;  end
      SP_NSXY:  begin opa = n_w;  opb = sxy_w; end
      SP_SXSY:  begin opa = sx_w; opb = sy_w;  end
      SP_SLOPE: begin alu_req.op = OP_RDIV; opa = nxy_r << 16; opb = dxx_r; end
      SP_SYSXX: begin opa = sy_w; opb = sxx_w; end
      SP_SXSXY: begin opa = sx_w; opb = sxy_w; end
      SP_ICPT:  begin alu_req.op = OP_RDIV; opa = t1_r << 8; opb = dxx_r; end
      SP_DD:    begin opa = dxx_r; opb = dyy_r; end
      SP_N2:    begin opa = nxy_r; opb = nxy_r; end
      SP_R2:    begin alu_req.op = OP_RDIV; opa = n2_r << 16; opb = dd_r; end
      SP_CDIV:  begin alu_req.op = OP_DIV;  opa = n2_r << 32; opb = dd_r; end
      SP_CSQRT: begin alu_req.op = OP_SQRT; opa = t1_r; end
      SP_A1:    begin opa = resid_r << 16; opb = nm1_w; end
      SP_A2:    begin opa = dd_r; opb = nm2_w; end
      SP_A3:    begin alu_req.op = OP_RDIV; opa = t1_r; opb = t2_r; end
      SP_E1:    begin opa = n_w;  opb = nm2_w; end
      SP_E2:    begin opa = t1_r; opb = dxx_r; end
      SP_E3:    begin alu_req.op = OP_DIV;  opa = resid_r << 16; opb = t2_r; end
      SP_E4:    begin alu_req.op = OP_SQRT; opa = t1_r; end
      default:  begin opa = n_w; opb = sxx_w; end
    endcase
  end

  lslf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (alu_req),
    .opa_i (opa),
    .opb_i (opb),
    .rsp_o (alu_rsp),
    .res_o (alu_res)
  );

  // Sequencer next state.
  always_comb begin
    ctl_nxt  = ctl_r;
    step_nxt = step_r;
    unique case (ctl_r)
      CT_IDLE: begin
        if (in_fire && in_data.last_point) begin
          ctl_nxt  = CT_LAUNCH;
          step_nxt = SP_NSXX;
        end
      end
      CT_LAUNCH: ctl_nxt = CT_WAIT;
      CT_WAIT: begin
        if (alu_rsp.done) begin
          if (fit_exit) begin
            ctl_nxt = CT_OUT;
          end else begin
            ctl_nxt  = CT_LAUNCH;
            step_nxt = step_t'(step_r + 5'd1);
          end
        end
      end
      CT_OUT: begin
        if (out_load) ctl_nxt = CT_IDLE;
      end
      default: ctl_nxt = CT_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = (ctl_r == CT_IDLE);
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CT_IDLE;
      step_r      <= SP_NSXX;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
    end else begin
      ctl_r       <= ctl_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire && (cnt_r < CNT_W'(MAX_POINTS))) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sx_r  <= sx_r + SUMX_W'(xs);
        sy_r  <= sy_r + SUMX_W'(ys);
        sxx_r <= sxx_r + SQ_W'(pxx);
        syy_r <= syy_r + SQ_W'(pyy);
        sxy_r <= sxy_r + XY_W'(pxy);
      end else if (out_load) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
      end
    end
  end

  // Fit datapath; every field starts at zero so early exits report zeros in fields not yet computed.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_point) begin
      slope_r  <= '0;
      icpt_r   <= '0;
      r2_r     <= '0;
      corr_r   <= '0;
      adj_r    <= '0;
      serr_r   <= '0;
      status_r <= FS_OK;
    end
    if (wb_en) begin
      case (step_r)
        SP_NSXX, SP_NSYY, SP_NSXY, SP_SYSXX, SP_CDIV, SP_A1, SP_E1, SP_E3: begin
          t1_r <= alu_res;
        end
        SP_SXSX:  dxx_r  <= t1_r - alu_res;
        SP_SYSY:  dyy_r  <= t1_r - alu_res;
        SP_SXSY: begin
          nxy_r <= t1_r - alu_res;
          if (fit_exit) status_r <= FS_X_FLAT;
        end
        SP_SLOPE: slope_r <= sat_s48(alu_res);
        SP_SXSXY: t1_r    <= t1_r - alu_res;
        SP_ICPT: begin
          icpt_r <= sat_s48(alu_res);
          if (cnt_r <= CNT_W'(2)) begin
            status_r <= FS_FEW_PTS;
          end else if (dyy_r == '0) begin
            status_r <= FS_Y_FLAT;
          end
        end
        SP_DD: dd_r <= alu_res;
        SP_N2: begin
          n2_r    <= alu_res;
          resid_r <= dd_r - alu_res;
        end
        SP_R2:    r2_r   <= 17'(clamp_u(alu_res, LIM_R2));
        SP_CSQRT: corr_r <= 17'(clamp_u(alu_res, LIM_R2));
        SP_A2, SP_E2: t2_r <= alu_res;
        SP_A3:    adj_r  <= adj_val;
        SP_E4:    serr_r <= 32'(clamp_u(alu_res, LIM_SE));
        default:  t1_r   <= t1_r;
      endcase
    end
    if (out_load) begin
      out_data_r.slope              <= slope_r;
      out_data_r.intercept          <= icpt_r;
      out_data_r.r_squared          <= r2_r;
      out_data_r.correlation        <= corr_r;
      out_data_r.adjusted_r_squared <= adj_r;
      out_data_r.standard_error     <= serr_r;
      out_data_r.point_count        <= 17'(cnt_r);
      out_data_r.fit_status         <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The shared unit is never started while it is still working.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  // A marked last sample always launches the first step of a fit.
  a_fit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_point) |=> (ctl_r == CT_LAUNCH && step_r == SP_NSXX))
    else $error("fit did not start after last sample");

  // Loading a result clears the sums for the next set.
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (cnt_r == '0 && out_valid_r))
    else $error("sums not cleared after result load");

  // R squared of a delivered word never exceeds one.
  a_r2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.r_squared <= 17'd65536))
    else $error("r_squared out of range");

endmodule
